FILE: rtl/gmb_pkg.sv
// Shared constants and types of the greedy meshlet builder.
package gmb_pkg;

   localparam int MAX_VERTS  = 64;
   localparam int MAX_TRIS   = 128;
   localparam int VERT_W     = 32;
   localparam int LOCAL_W    = 6;
   localparam int SLOT_W     = $clog2(MAX_VERTS);
   localparam int VFILL_W    = $clog2(MAX_VERTS + 1);
   localparam int TFILL_W    = $clog2(MAX_TRIS + 1);
   localparam int VLIM_RAW_W = 7;
   localparam int TLIM_RAW_W = 8;
   localparam int CSR_W      = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CLAMP_W    = 10;
   localparam int CORNERS    = 3;

   localparam logic [CSR_IDX_W-1:0] REG_VERTEX_LIMIT   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TRIANGLE_LIMIT = 1'd1;

   localparam logic [VLIM_RAW_W-1:0] VLIM_RESET = 7'd64;
   localparam logic [TLIM_RAW_W-1:0] TLIM_RESET = 8'd124;

   typedef struct packed {
      logic [VFILL_W-1:0] vertex_limit;
      logic [TFILL_W-1:0] triangle_limit;
   } limits_type;

   typedef struct packed {
      logic [CORNERS-1:0]             found;
      logic [CORNERS-1:0][SLOT_W-1:0] slot;
   } match_type;

   typedef struct packed {
      logic [CORNERS-1:0]             en;
      logic [CORNERS-1:0][SLOT_W-1:0] addr;
   } store_write_type;

endpackage

FILE: rtl/gmb_cfg.sv
// Limit registers of the meshlet builder, with clamped working values.
module gmb_cfg (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [gmb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gmb_pkg::CSR_W-1:0]       csr_wdata,
   output gmb_pkg::limits_type             limits
);

   logic [gmb_pkg::VLIM_RAW_W-1:0] vlim_ff;
   logic [gmb_pkg::TLIM_RAW_W-1:0] tlim_ff;
   logic [gmb_pkg::CLAMP_W-1:0]    vlim_wide;
   logic [gmb_pkg::CLAMP_W-1:0]    tlim_wide;
   logic [gmb_pkg::CLAMP_W-1:0]    vlim_clamped;
   logic [gmb_pkg::CLAMP_W-1:0]    tlim_clamped;

   always_ff @(posedge clock) begin
      if (reset) begin
         vlim_ff <= gmb_pkg::VLIM_RESET;
         tlim_ff <= gmb_pkg::TLIM_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            gmb_pkg::REG_VERTEX_LIMIT: begin
               vlim_ff <= csr_wdata[gmb_pkg::VLIM_RAW_W-1:0];
            end
            gmb_pkg::REG_TRIANGLE_LIMIT: begin
               tlim_ff <= csr_wdata[gmb_pkg::TLIM_RAW_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // clamp vertex limit to [3, MAX_VERTS] and triangle limit to [1, MAX_TRIS]
   always_comb begin
      vlim_wide = gmb_pkg::CLAMP_W'(vlim_ff);
      tlim_wide = gmb_pkg::CLAMP_W'(tlim_ff);
      if (vlim_wide < gmb_pkg::CLAMP_W'(3)) begin
         vlim_clamped = gmb_pkg::CLAMP_W'(3);
      end else if (vlim_wide > gmb_pkg::CLAMP_W'(gmb_pkg::MAX_VERTS)) begin
         vlim_clamped = gmb_pkg::CLAMP_W'(gmb_pkg::MAX_VERTS);
      end else begin
         vlim_clamped = vlim_wide;
      end
      if (tlim_wide < gmb_pkg::CLAMP_W'(1)) begin
         tlim_clamped = gmb_pkg::CLAMP_W'(1);
      end else if (tlim_wide > gmb_pkg::CLAMP_W'(gmb_pkg::MAX_TRIS)) begin
         tlim_clamped = gmb_pkg::CLAMP_W'(gmb_pkg::MAX_TRIS);
      end else begin
         tlim_clamped = tlim_wide;
      end
      limits.vertex_limit   = vlim_clamped[gmb_pkg::VFILL_W-1:0];
      limits.triangle_limit = tlim_clamped[gmb_pkg::TFILL_W-1:0];
   end

endmodule

FILE: rtl/gmb_vstore.sv
// Vertex store of the open meshlet with a parallel compare for three corners.
module gmb_vstore (
   input  logic                                          clock,
   input  logic [gmb_pkg::VFILL_W-1:0]                   fill,
   input  logic [gmb_pkg::CORNERS-1:0][gmb_pkg::VERT_W-1:0] vertex,
   input  gmb_pkg::store_write_type                      wr,
   output gmb_pkg::match_type                            match
);

   logic [gmb_pkg::MAX_VERTS-1:0][gmb_pkg::VERT_W-1:0] store_ff;

   // write up to three new vertices; addresses are distinct
   always_ff @(posedge clock) begin
      for (int i = 0; i < gmb_pkg::MAX_VERTS; i++) begin
         for (int k = 0; k < gmb_pkg::CORNERS; k++) begin
            if (wr.en[k] && (wr.addr[k] == gmb_pkg::SLOT_W'(i))) begin
               store_ff[i] <= vertex[k];
            end
         end
      end
   end

   // only entries below the fill are live; live entries are distinct, so hits are one-hot
   always_comb begin
      for (int k = 0; k < gmb_pkg::CORNERS; k++) begin
         match.found[k] = 1'b0;
         match.slot[k]  = '0;
         for (int i = 0; i < gmb_pkg::MAX_VERTS; i++) begin
            if ((gmb_pkg::VFILL_W'(i) < fill) && (store_ff[i] == vertex[k])) begin
               match.found[k] = 1'b1;
               match.slot[k]  = match.slot[k] | gmb_pkg::SLOT_W'(i);
            end
         end
      end
   end

endmodule

FILE: rtl/greedy_meshlet_builder.sv
// Top level of the greedy meshlet builder: input stage, placement logic, result stage.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  vertex_a/b/c, final_triangle
//   rsp      out        rsp_valid/rsp_ready  meshlet_index, local_a/b/c, opens_meshlet,
//                                            meshlet_total, final_result
//   csr      in         csr_wr_en            csr_index, csr_wdata
//
// One triangle per cycle sustained while rsp_ready stays high; the result passes through
// the input register and then the result register before rsp_valid rises.
// The rate rests on the combinational compare of the three corners against the
// 64-entry vertex store, placed between the input register and the result register.
// Synchronous reset clears the fills, the meshlet counter and both stage valids;
// the store itself needs no clearing since only entries below the fill are compared.
// A stall on rsp holds the result register and then the input register.
module greedy_meshlet_builder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [gmb_pkg::VERT_W-1:0]        req_vertex_a,
   input  logic [gmb_pkg::VERT_W-1:0]        req_vertex_b,
   input  logic [gmb_pkg::VERT_W-1:0]        req_vertex_c,
   input  logic                              req_final_triangle,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [31:0]                       rsp_meshlet_index,
   output logic [gmb_pkg::LOCAL_W-1:0]       rsp_local_a,
   output logic [gmb_pkg::LOCAL_W-1:0]       rsp_local_b,
   output logic [gmb_pkg::LOCAL_W-1:0]       rsp_local_c,
   output logic                              rsp_opens_meshlet,
   output logic [31:0]                       rsp_meshlet_total,
   output logic                              rsp_final_result,
   input  logic                              csr_wr_en,
   input  logic [gmb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gmb_pkg::CSR_W-1:0]         csr_wdata
);

   gmb_pkg::limits_type      limits;
   gmb_pkg::match_type       match;
   gmb_pkg::store_write_type wr;

   // input stage
   logic                     in_valid_ff, in_valid_in;
   logic [gmb_pkg::CORNERS-1:0][gmb_pkg::VERT_W-1:0] in_vertex_ff;
   logic                     in_final_ff;

   // mesh state
   logic [gmb_pkg::VFILL_W-1:0] vfill_ff, vfill_in;
   logic [gmb_pkg::TFILL_W-1:0] tfill_ff, tfill_in;
   logic [31:0]                 meshlet_ff, meshlet_in;
   logic                        any_seen_ff, any_seen_in;

   // result stage
   logic                        out_valid_ff, out_valid_in;
   logic [31:0]                 out_meshlet_ff;
   logic [gmb_pkg::CORNERS-1:0][gmb_pkg::LOCAL_W-1:0] out_local_ff;
   logic                        out_opens_ff;
   logic [31:0]                 out_total_ff;
   logic                        out_final_ff;

   // placement
   logic                        req_accept;
   logic                        advance;
   logic                        dup_b_a, dup_c_a, dup_c_b;
   logic                        fresh_a, fresh_b, fresh_c;
   logic [1:0]                  fresh_cnt;
   logic                        opens;
   logic [gmb_pkg::VFILL_W:0]   need_fill;
   logic [gmb_pkg::VFILL_W-1:0] base_fill;
   logic                        hit_a, hit_b, hit_c;
   logic                        new_a, new_b, new_c;
   logic [gmb_pkg::VFILL_W-1:0] addr_a, addr_b, addr_c;
   logic [gmb_pkg::SLOT_W-1:0]  slot_a, slot_b, slot_c;
   logic [gmb_pkg::VFILL_W-1:0] fill_after;
   logic [gmb_pkg::TFILL_W-1:0] tfill_after;
   logic [31:0]                 meshlet_after;

   gmb_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .limits    (limits)
   );

   gmb_vstore u_vstore (
      .clock  (clock),
      .fill   (vfill_ff),
      .vertex (in_vertex_ff),
      .wr     (wr),
      .match  (match)
   );

   // handshake: the input stage moves on whenever the result stage is free or drains
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // count vertices the triangle brings, against the store as it stands
   always_comb begin
      dup_b_a   = in_vertex_ff[1] == in_vertex_ff[0];
      dup_c_a   = in_vertex_ff[2] == in_vertex_ff[0];
      dup_c_b   = in_vertex_ff[2] == in_vertex_ff[1];
      fresh_a   = !match.found[0];
      fresh_b   = !match.found[1] && !dup_b_a;
      fresh_c   = !match.found[2] && !dup_c_a && !dup_c_b;
      fresh_cnt = 2'(fresh_a) + 2'(fresh_b) + 2'(fresh_c);
      need_fill = (gmb_pkg::VFILL_W+1)'(vfill_ff) + (gmb_pkg::VFILL_W+1)'(fresh_cnt);
      opens     = !any_seen_ff
                  || (tfill_ff >= limits.triangle_limit)
                  || (need_fill > (gmb_pkg::VFILL_W+1)'(limits.vertex_limit));
   end

   // a new meshlet starts from an empty store; allocate slots in corner order.
   // A join never overflows the store since fill plus fresh stays within the limit.
   always_comb begin
      base_fill = opens ? '0 : vfill_ff;
      hit_a     = match.found[0] && !opens;
      hit_b     = match.found[1] && !opens;
      hit_c     = match.found[2] && !opens;
      new_a     = !hit_a;
      new_b     = !hit_b && !dup_b_a;
      new_c     = !hit_c && !dup_c_a && !dup_c_b;
      addr_a    = base_fill;
      addr_b    = base_fill + gmb_pkg::VFILL_W'(new_a);
      addr_c    = addr_b + gmb_pkg::VFILL_W'(new_b);
      fill_after = addr_c + gmb_pkg::VFILL_W'(new_c);

      slot_a = hit_a ? match.slot[0] : addr_a[gmb_pkg::SLOT_W-1:0];
      if (hit_b) begin
         slot_b = match.slot[1];
      end else if (dup_b_a) begin
         slot_b = slot_a;
      end else begin
         slot_b = addr_b[gmb_pkg::SLOT_W-1:0];
      end
      if (hit_c) begin
         slot_c = match.slot[2];
      end else if (dup_c_a) begin
         slot_c = slot_a;
      end else if (dup_c_b) begin
         slot_c = slot_b;
      end else begin
         slot_c = addr_c[gmb_pkg::SLOT_W-1:0];
      end

      wr.en[0]   = advance && new_a;
      wr.en[1]   = advance && new_b;
      wr.en[2]   = advance && new_c;
      wr.addr[0] = addr_a[gmb_pkg::SLOT_W-1:0];
      wr.addr[1] = addr_b[gmb_pkg::SLOT_W-1:0];
      wr.addr[2] = addr_c[gmb_pkg::SLOT_W-1:0];

      tfill_after   = (opens ? '0 : tfill_ff) + gmb_pkg::TFILL_W'(1);
      meshlet_after = (opens && any_seen_ff) ? meshlet_ff + 32'd1 : meshlet_ff;
   end

   // advance mesh state; drop back to an empty mesh after the final triangle
   always_comb begin
      vfill_in    = vfill_ff;
      tfill_in    = tfill_ff;
      meshlet_in  = meshlet_ff;
      any_seen_in = any_seen_ff;
      if (advance) begin
         if (in_final_ff) begin
            vfill_in    = '0;
            tfill_in    = '0;
            meshlet_in  = '0;
            any_seen_in = 1'b0;
         end else begin
            vfill_in    = fill_after;
            tfill_in    = tfill_after;
            meshlet_in  = meshlet_after;
            any_seen_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         vfill_ff     <= '0;
         tfill_ff     <= '0;
         meshlet_ff   <= '0;
         any_seen_ff  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         vfill_ff     <= vfill_in;
         tfill_ff     <= tfill_in;
         meshlet_ff   <= meshlet_in;
         any_seen_ff  <= any_seen_in;
      end
   end

   // payload registers: load on accept / advance, hold otherwise
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_vertex_ff[0] <= req_vertex_a;
         in_vertex_ff[1] <= req_vertex_b;
         in_vertex_ff[2] <= req_vertex_c;
         in_final_ff     <= req_final_triangle;
      end
      if (advance) begin
         out_meshlet_ff  <= meshlet_after;
         out_local_ff[0] <= gmb_pkg::LOCAL_W'(slot_a);
         out_local_ff[1] <= gmb_pkg::LOCAL_W'(slot_b);
         out_local_ff[2] <= gmb_pkg::LOCAL_W'(slot_c);
         out_opens_ff    <= opens;
         out_total_ff    <= in_final_ff ? meshlet_after + 32'd1 : 32'd0;
         out_final_ff    <= in_final_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_meshlet_index = out_meshlet_ff;
   assign rsp_local_a       = out_local_ff[0];
   assign rsp_local_b       = out_local_ff[1];
   assign rsp_local_c       = out_local_ff[2];
   assign rsp_opens_meshlet = out_opens_ff;
   assign rsp_meshlet_total = out_total_ff;
   assign rsp_final_result  = out_final_ff;

endmodule
